// ===== rtl/core/voxel_set_face_culler_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel set face culler assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SET_FACE_CULLER_DEFINES_SVH
`define VOXEL_SET_FACE_CULLER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define VSFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define VSFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel set face culler package
// Word field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package vsfc_pkg;

  localparam int COORD_W   = 16;
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 9;
  localparam int MASK_W    = 6;

  // Face bit positions in the visibility mask
  localparam int FACE_NEG_Y = 0;
  localparam int FACE_POS_Y = 1;
  localparam int FACE_NEG_X = 2;
  localparam int FACE_POS_X = 3;
  localparam int FACE_NEG_Z = 4;
  localparam int FACE_POS_Z = 5;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_QREAD,
    S_QCAP,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/vsfc_if.sv =====
// ----------------------------------------------------------------------------
// Voxel set face culler channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface vsfc_in_if;
  import vsfc_pkg::*;

  logic                      valid;
  logic                      ready;
  op_e                       op;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_z;
  logic [IDX_W-1:0]          entry_index;

  modport source (output valid, op, in_x, in_y, in_z, entry_index, input ready);
  modport sink   (input valid, op, in_x, in_y, in_z, entry_index, output ready);
endinterface

interface vsfc_out_if;
  import vsfc_pkg::*;

  logic                      valid;
  logic                      ready;
  status_e                   status;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [MASK_W-1:0]         face_mask;
  logic [CNT_OUT_W-1:0]      entry_count;

  modport source (output valid, status, out_x, out_y, out_z, face_mask, entry_count,
                  input ready);
  modport sink   (input valid, status, out_x, out_y, out_z, face_mask, entry_count,
                  output ready);
endinterface

// ===== rtl/core/voxel_set_face_culler.sv =====
// ----------------------------------------------------------------------------
// Voxel set face culler
// Holds an ordered set of up to MAX_VOXELS distinct voxels in one RAM and
// answers add, delete, clear and face-visibility query commands, one result
// word per command word. Every pass over the set goes through the single RAM
// read port, one entry per cycle: add scans the whole set; delete scans it
// and then moves each later entry down by one to close the gap; query reads
// its entry and then scans the set (all six neighbors are compared against
// each entry in the same pass); clear and an out-of-range query need no
// pass. The block takes no new word while a command is in progress; a
// finished result waits in the output register and does not hold off the
// next command. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "voxel_set_face_culler_defines.svh"

module voxel_set_face_culler #(
  parameter int MAX_VOXELS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  vsfc_in_if.sink    in_i,
  vsfc_out_if.source out_o
);
  import vsfc_pkg::*;

  localparam int CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int AW     = $clog2(MAX_VOXELS);
  localparam int CNT_W  = $clog2(MAX_VOXELS + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int WORD_W = 3 * CW;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VOXELS);

  // Sequencer and set state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pend_idx_q, pend_idx_d;
  logic               found_q, found_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [MASK_W-1:0]  hit_q, hit_d;
  op_e                op_q, op_d;
  status_e            status_q, status_d;
  logic signed [CW-1:0] tgt_x_q, tgt_x_d;
  logic signed [CW-1:0] tgt_y_q, tgt_y_d;
  logic signed [CW-1:0] tgt_z_q, tgt_z_d;

  // Output register
  logic                      out_valid_q;
  status_e                   out_status_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [MASK_W-1:0]         out_mask_q;
  logic [CNT_OUT_W-1:0]      out_count_q;
  logic                      out_load;

  // RAM ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Scan datapath
  logic signed [CW-1:0] ent_x, ent_y, ent_z;
  logic [CW:0]          xm, xp, ym, yp, zm, zp;
  logic [MASK_W-1:0]    lane_hit;
  logic                 self_hit;
  logic                 issue;
  logic                 scan_done;
  logic                 idx_ok;
  logic                 accept;

  vsfc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_VOXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Split the stored word
  assign ent_x = ram_rdata[3*CW-1:2*CW];
  assign ent_y = ram_rdata[2*CW-1:CW];
  assign ent_z = ram_rdata[CW-1:0];

  // Neighbor coordinates, one bit wider to catch leaving the range
  assign xm = (CW+1)'(tgt_x_q) - (CW+1)'(1);
  assign xp = (CW+1)'(tgt_x_q) + (CW+1)'(1);
  assign ym = (CW+1)'(tgt_y_q) - (CW+1)'(1);
  assign yp = (CW+1)'(tgt_y_q) + (CW+1)'(1);
  assign zm = (CW+1)'(tgt_z_q) - (CW+1)'(1);
  assign zp = (CW+1)'(tgt_z_q) + (CW+1)'(1);

  // Compare one entry against the target and its six neighbors
  always_comb begin
    self_hit = (ent_x == tgt_x_q) && (ent_y == tgt_y_q) && (ent_z == tgt_z_q);
    lane_hit[FACE_NEG_Y] = (ym[CW] == ym[CW-1]) && (ent_y == ym[CW-1:0]) &&
                           (ent_x == tgt_x_q) && (ent_z == tgt_z_q);
    lane_hit[FACE_POS_Y] = (yp[CW] == yp[CW-1]) && (ent_y == yp[CW-1:0]) &&
                           (ent_x == tgt_x_q) && (ent_z == tgt_z_q);
    lane_hit[FACE_NEG_X] = (xm[CW] == xm[CW-1]) && (ent_x == xm[CW-1:0]) &&
                           (ent_y == tgt_y_q) && (ent_z == tgt_z_q);
    lane_hit[FACE_POS_X] = (xp[CW] == xp[CW-1]) && (ent_x == xp[CW-1:0]) &&
                           (ent_y == tgt_y_q) && (ent_z == tgt_z_q);
    lane_hit[FACE_NEG_Z] = (zm[CW] == zm[CW-1]) && (ent_z == zm[CW-1:0]) &&
                           (ent_x == tgt_x_q) && (ent_y == tgt_y_q);
    lane_hit[FACE_POS_Z] = (zp[CW] == zp[CW-1]) && (ent_z == zp[CW-1:0]) &&
                           (ent_x == tgt_x_q) && (ent_y == tgt_y_q);
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign idx_ok     = CMP_W'(in_i.entry_index) < CMP_W'(count_q);
  assign issue      = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (idx_q < count_q);
  assign scan_done  = !issue && !pend_q;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Next state and datapath control
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    pos_d      = pos_q;
    hit_d      = hit_q;
    op_d       = op_q;
    status_d   = status_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    tgt_z_d    = tgt_z_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[AW-1:0];
    ram_wdata  = {tgt_x_q, tgt_y_q, tgt_z_q};
    ram_re     = 1'b0;
    ram_raddr  = idx_q[AW-1:0];

    // Walk the set one entry per cycle
    if (issue) begin
      ram_re     = 1'b1;
      pend_d     = 1'b1;
      pend_idx_d = idx_q[AW-1:0];
      idx_d      = idx_q + CNT_W'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_i.op;
          tgt_x_d = in_i.in_x[CW-1:0];
          tgt_y_d = in_i.in_y[CW-1:0];
          tgt_z_d = in_i.in_z[CW-1:0];
          found_d = 1'b0;
          hit_d   = '0;
          idx_d   = '0;
          case (in_i.op)
            OP_ADD, OP_DEL: begin
              state_d = S_SCAN;
            end
            OP_CLEAR: begin
              count_d  = '0;
              status_d = ST_DONE;
              state_d  = S_DONE;
            end
            OP_QUERY: begin
              if (idx_ok) begin
                idx_d   = CNT_W'(in_i.entry_index);
                state_d = S_QREAD;
              end else begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_QREAD: begin
        ram_re  = 1'b1;
        state_d = S_QCAP;
      end

      // Latch the queried voxel, then scan for its neighbors
      S_QCAP: begin
        tgt_x_d = ram_rdata[3*CW-1:2*CW];
        tgt_y_d = ram_rdata[2*CW-1:CW];
        tgt_z_d = ram_rdata[CW-1:0];
        idx_d   = '0;
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (pend_q) begin
          if (op_q == OP_QUERY) begin
            hit_d = hit_q | lane_hit;
          end else if (self_hit && !found_q) begin
            found_d = 1'b1;
            pos_d   = pend_idx_q;
          end
        end
        if (scan_done) begin
          state_d  = S_DONE;
          status_d = ST_DONE;
          case (op_q)
            OP_ADD: begin
              if (found_q) begin
                status_d = ST_DUP;
              end else if (count_q == MAX_CNT) begin
                status_d = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_DEL: begin
              if (!found_q) begin
                status_d = ST_NOT_FOUND;
              end else begin
                idx_d   = CNT_W'(pos_q) + CNT_W'(1);
                state_d = S_SHIFT;
              end
            end
            default: begin
              status_d = ST_DONE;
            end
          endcase
        end
      end

      // Move each later entry down by one
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (scan_done) begin
          count_d  = count_q - CNT_W'(1);
          status_d = ST_DONE;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    hit_q      <= hit_d;
    op_q       <= op_d;
    status_q   <= status_d;
    tgt_x_q    <= tgt_x_d;
    tgt_y_q    <= tgt_y_d;
    tgt_z_q    <= tgt_z_d;
  end

  // Load the result word; coordinates and mask only for a good query
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= CNT_OUT_W'(count_q);
      if ((op_q == OP_QUERY) && (status_q == ST_DONE)) begin
        out_x_q    <= COORD_W'(tgt_x_q);
        out_y_q    <= COORD_W'(tgt_y_q);
        out_z_q    <= COORD_W'(tgt_z_q);
        out_mask_q <= ~hit_q;
      end else begin
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_z_q    <= '0;
        out_mask_q <= '0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.out_x       = out_x_q;
  assign out_o.out_y       = out_y_q;
  assign out_o.out_z       = out_z_q;
  assign out_o.face_mask   = out_mask_q;
  assign out_o.entry_count = out_count_q;

  // Reads in flight belong to a pass over the set
  `VSFC_ASSERT_SAME(a_pend_in_pass, pend_q, (state_q == S_SCAN) || (state_q == S_SHIFT), "read in flight outside a pass")
  // The pass index never runs past the fill count
  `VSFC_ASSERT_SAME(a_idx_bound, (state_q == S_SCAN) || (state_q == S_SHIFT), idx_q <= count_q, "pass index beyond count")
  // The fill count never exceeds capacity
  `VSFC_ASSERT_NEXT(a_cnt_cap, count_q <= MAX_CNT, count_q <= MAX_CNT, "count exceeds capacity")
  // Outside clear the count moves by at most one per command
  `VSFC_ASSERT_NEXT(a_cnt_step, state_q != S_IDLE, (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)), "count jumped")
  // A committed add grows the set by one
  `VSFC_ASSERT_NEXT(a_add_grow, (state_q == S_SCAN) && scan_done && (op_q == OP_ADD) && !found_q && (count_q != MAX_CNT), count_q == $past(count_q) + CNT_W'(1), "add did not grow set")

endmodule

// ===== rtl/core/vsfc_ram.sv =====
// ----------------------------------------------------------------------------
// Voxel set face culler RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vsfc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
